### rtl/canonical_huffman_decoder_core_macros.svh
// Assertion macros shared by the checker of the canonical Huffman decoder core.
`ifndef CANONICAL_HUFFMAN_DECODER_CORE_MACROS_SVH
`define CANONICAL_HUFFMAN_DECODER_CORE_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define CHD_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Concurrent assertion on the block's own clock and reset.
`define CHD_ASSERT(lbl, prop) `CHD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### rtl/chd_pkg.sv
// Types and codes shared by the canonical Huffman decoder modules.
package chd_pkg;

  // Width of one stored code length and the longest length that can be stored.
  localparam int unsigned LEN_W = 6;
  localparam logic [LEN_W-1:0] LEN_TOP = '1;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // Action codes of an input word.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_BIT   = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] ST_BYTE     = 2'd0;
  localparam logic [1:0] ST_END      = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_BUILT    = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [8:0]       symbol_index;
    logic [LEN_W-1:0] code_length;
    logic             coded_bit;
  } chd_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] decoded_byte;
  } chd_out_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_BUILD,
    CMD_BIT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [8:0]       symbol_index;
    logic [LEN_W-1:0] code_length;
    logic             coded_bit;
  } chd_cmd_t;

  // Handshake of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } chd_q_stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_SCAN_END,
    BK_LOOK,
    BK_SYM
  } back_state_e;

endpackage

### rtl/canonical_huffman_decoder_core.sv
// Top level of the canonical Huffman decoder core.
// After reset the core clears its length store, one symbol a cycle, and holds
// busy high meanwhile. Words are taken while start is high and busy low; busy
// is also high whenever the two-entry command queue is full. The back end
// handles a length load from its idle state; a coded bit passes through the
// idle and look states, and through the symbol state when it completes a code;
// a build scans the whole length store once for every possible code length,
// one store read a cycle. Results appear on result_o for one cycle, marked by
// done_o, and must be taken then.
module canonical_huffman_decoder_core #(
  parameter int unsigned SYMBOL_COUNT  = 257,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  chd_pkg::chd_in_t  item_i,
  output logic              done_o,
  output chd_pkg::chd_out_t result_o
);
  import chd_pkg::*;

  logic        push, pop, clearing;
  chd_cmd_t    push_cmd, pop_cmd;
  chd_q_stat_t q_stat;

  // Word intake and classification.
  chd_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .clearing_i(clearing),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Command queue.
  chd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .pop_cmd_o (pop_cmd),
    .stat_o    (q_stat)
  );

  // Table build and decoding.
  chd_back #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .clearing_o(clearing),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule

### rtl/chd_queue.sv
// Short command queue between the front and the back of the decoder.
module chd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  chd_pkg::chd_cmd_t push_cmd_i,
  input  logic              pop_i,
  output chd_pkg::chd_cmd_t pop_cmd_o,
  output chd_pkg::chd_q_stat_t stat_o
);
  import chd_pkg::*;

  chd_cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_cmd_o    = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

endmodule

### rtl/chd_front.sv
// Front of the decoder: takes input words, sorts them into commands and queues them.
module chd_front #(
  parameter int unsigned SYMBOL_COUNT = 257
) (
  input  logic                 start,
  output logic                 busy,
  input  chd_pkg::chd_in_t     item_i,
  input  logic                 clearing_i,
  input  chd_pkg::chd_q_stat_t q_stat_i,
  output logic                 push_o,
  output chd_pkg::chd_cmd_t    cmd_o
);
  import chd_pkg::*;

  logic accept;

  // The front stalls while the queue is full or the length store is being cleared.
  assign busy   = q_stat_i.full | clearing_i;
  assign accept = start & ~busy;

  // Classify the word; unknown actions and out-of-range loads are dropped here.
  always_comb begin
    cmd_o.kind         = CMD_BIT;
    cmd_o.symbol_index = item_i.symbol_index;
    cmd_o.code_length  = item_i.code_length;
    cmd_o.coded_bit    = item_i.coded_bit;
    push_o             = 1'b0;
    case (item_i.action)
      ACT_LOAD: begin
        cmd_o.kind = CMD_LOAD;
        push_o     = accept && (int'(item_i.symbol_index) < SYMBOL_COUNT);
      end
      ACT_BUILD: begin
        cmd_o.kind = CMD_BUILD;
        push_o     = accept;
      end
      ACT_BIT: begin
        cmd_o.kind = CMD_BIT;
        push_o     = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/chd_back.sv
// Back of the decoder: length store, code table build and bit-by-bit decoding.
module chd_back #(
  parameter int unsigned SYMBOL_COUNT  = 257,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chd_pkg::chd_q_stat_t q_stat_i,
  input  chd_pkg::chd_cmd_t    cmd_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 done_o,
  output chd_pkg::chd_out_t    result_o
);
  import chd_pkg::*;

  localparam int unsigned SIW  = $clog2(SYMBOL_COUNT);
  localparam int unsigned CNW  = $clog2(SYMBOL_COUNT + 1);
  localparam int unsigned TW   = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned MCB  = MAX_CODE_BITS;
  localparam int unsigned CMPW = (MCB > CNW) ? MCB : CNW;
  localparam logic [SIW-1:0] LAST_SYM = SIW'(SYMBOL_COUNT - 1);

  back_state_e state_q, state_d;

  // Memories and their read registers.
  logic [LEN_W-1:0] len_mem [SYMBOL_COUNT];
  logic [SIW-1:0]   ord_mem [SYMBOL_COUNT];
  logic [CNW-1:0]   cnt_mem [MAX_CODE_BITS+1];
  logic [SIW-1:0]   first_mem [MAX_CODE_BITS+1];
  logic [CNW-1:0]   fc_mem [MAX_CODE_BITS+1];
  logic [LEN_W-1:0] len_rd_q;
  logic [SIW-1:0]   ord_rd_q;
  logic [CNW-1:0]   cnt_rd_q, fc_rd_q;
  logic [SIW-1:0]   first_rd_q;

  logic             len_we, ord_we, tab_we;
  logic [SIW-1:0]   len_wa, ord_wa, ord_ra;
  logic [LEN_W-1:0] len_wd;
  logic [SIW-1:0]   ord_wd;
  logic [TW-1:0]    tab_wa, tab_ra;
  logic [CNW-1:0]   tab_cnt_wd, tab_fc_wd;
  logic [SIW-1:0]   tab_first_wd;

  // Build state.
  logic [SIW-1:0]   clr_q, clr_d, s_q, s_d;
  logic [LEN_W-1:0] len_q, len_d, prev_q, prev_d;
  logic             p_valid_q, p_valid_d, p_last_q, p_last_d;
  logic [SIW-1:0]   p_sym_q, p_sym_d;
  logic [LEN_W-1:0] p_len_q, p_len_d;
  logic [CNW-1:0]   cnt_q, cnt_d, nxt_q, nxt_d, code_q, code_d;
  logic [MCB:0]     tvalid_q, tvalid_d;

  // Decode state.
  logic             ready_q, ready_d, end_q, end_d;
  logic [MCB-1:0]   bits_q, bits_d;
  logic [TW-1:0]    bcnt_q, bcnt_d;
  logic             done_q, done_d;
  chd_out_t         res_q, res_d;

  // Scan and decode datapath.
  logic             scan_hit;
  logic [CNW-1:0]   cnt_fin, nxt_new, shifted;
  logic [TW-1:0]    bcnt_new;
  logic [MCB-1:0]   bits_new, dec_mask, dec_diff;
  logic             dec_hit;
  logic [CNW-1:0]   dec_off;

  assign clearing_o = (state_q == BK_CLEAR);
  assign done_o     = done_q;
  assign result_o   = res_q;

  // Next gathered bits for an incoming coded bit.
  assign bcnt_new = (bcnt_q == TW'(MCB)) ? TW'(1) : bcnt_q + 1'b1;
  assign bits_new = {bits_q[MCB-2:0], cmd_i.coded_bit} & ~({MCB{1'b1}} << bcnt_new);

  // Match of the gathered bits against the codes of the current length.
  assign dec_mask = ~({MCB{1'b1}} << bcnt_q);
  assign dec_diff = (bits_q - MCB'(fc_rd_q)) & dec_mask;
  assign dec_hit  = tvalid_q[bcnt_q] && (CMPW'(dec_diff) < CMPW'(cnt_rd_q));
  assign dec_off  = (cnt_rd_q - 1'b1 - CNW'(dec_diff)) & CNW'(dec_mask);

  // Length store: cleared after reset, loaded by commands, read by the scan.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    len_rd_q <= len_mem[s_q];
  end

  // Symbols in canonical order.
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_rd_q <= ord_mem[ord_ra];
  end

  // Per-length count, first index and first code.
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      cnt_mem[tab_wa]   <= tab_cnt_wd;
      first_mem[tab_wa] <= tab_first_wd;
      fc_mem[tab_wa]    <= tab_fc_wd;
    end
    cnt_rd_q   <= cnt_mem[tab_ra];
    first_rd_q <= first_mem[tab_ra];
    fc_rd_q    <= fc_mem[tab_ra];
  end

  // Control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_q     <= '0;
      s_q       <= '0;
      len_q     <= '0;
      prev_q    <= '0;
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      cnt_q     <= '0;
      nxt_q     <= '0;
      code_q    <= '0;
      tvalid_q  <= '0;
      ready_q   <= 1'b0;
      end_q     <= 1'b0;
      bits_q    <= '0;
      bcnt_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      s_q       <= s_d;
      len_q     <= len_d;
      prev_q    <= prev_d;
      p_valid_q <= p_valid_d;
      p_last_q  <= p_last_d;
      cnt_q     <= cnt_d;
      nxt_q     <= nxt_d;
      code_q    <= code_d;
      tvalid_q  <= tvalid_d;
      ready_q   <= ready_d;
      end_q     <= end_d;
      bits_q    <= bits_d;
      bcnt_q    <= bcnt_d;
      done_q    <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p_sym_q <= p_sym_d;
    p_len_q <= p_len_d;
    res_q   <= res_d;
  end

  // Next state, scan pipeline and decode steps.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    s_d          = s_q;
    len_d        = len_q;
    prev_d       = prev_q;
    p_valid_d    = 1'b0;
    p_last_d     = 1'b0;
    p_sym_d      = s_q;
    p_len_d      = len_q;
    cnt_d        = cnt_q;
    nxt_d        = nxt_q;
    code_d       = code_q;
    tvalid_d     = tvalid_q;
    ready_d      = ready_q;
    end_d        = end_q;
    bits_d       = bits_q;
    bcnt_d       = bcnt_q;
    done_d       = 1'b0;
    res_d        = res_q;
    pop_o        = 1'b0;
    len_we       = 1'b0;
    len_wa       = SIW'(cmd_i.symbol_index);
    len_wd       = cmd_i.code_length;
    ord_we       = 1'b0;
    ord_wa       = SIW'(nxt_q - 1'b1);
    ord_wd       = p_sym_q;
    ord_ra       = first_rd_q + SIW'(dec_off);
    tab_we       = 1'b0;
    tab_wa       = TW'(p_len_q);
    tab_ra       = bcnt_new;
    scan_hit     = p_valid_q && (len_rd_q == p_len_q);
    cnt_fin      = cnt_q + CNW'(scan_hit);
    nxt_new      = nxt_q - CNW'(scan_hit);
    shifted      = code_q >> (prev_q - p_len_q);
    tab_cnt_wd   = cnt_fin;
    tab_first_wd = SIW'(nxt_new);
    tab_fc_wd    = shifted;

    // Scan pipeline: place matching symbols from the top of the order store
    // downwards, and record count and first code of each used length up to MAX_CODE_BITS.
    if (p_valid_q) begin
      ord_we = scan_hit;
      nxt_d  = nxt_new;
      cnt_d  = cnt_fin;
      if (p_last_q) begin
        cnt_d = '0;
        if (cnt_fin != '0) begin
          if (int'(p_len_q) <= MAX_CODE_BITS) begin
            tab_we           = 1'b1;
            tvalid_d[tab_wa] = 1'b1;
          end
          code_d = shifted + cnt_fin;
          prev_d = p_len_q;
        end
      end
    end

    case (state_q)
      BK_CLEAR: begin
        len_we = 1'b1;
        len_wa = clr_q;
        len_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LAST_SYM) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_LOAD: begin
              len_we = 1'b1;
            end
            CMD_BUILD: begin
              tvalid_d = '0;
              s_d      = LAST_SYM;
              len_d    = LEN_TOP;
              prev_d   = LEN_TOP;
              nxt_d    = CNW'(SYMBOL_COUNT);
              cnt_d    = '0;
              code_d   = '0;
              state_d  = BK_SCAN;
            end
            CMD_BIT: begin
              if (ready_q && !end_q) begin
                bcnt_d  = bcnt_new;
                bits_d  = bits_new;
                state_d = BK_LOOK;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        // One stored length per cycle, lengths from longest down to one.
        p_valid_d = 1'b1;
        p_last_d  = (s_q == '0);
        if (s_q == '0) begin
          s_d   = LAST_SYM;
          len_d = len_q - 1'b1;
          if (len_q == LEN_W'(1)) begin
            state_d = BK_SCAN_END;
          end
        end else begin
          s_d = s_q - 1'b1;
        end
      end
      BK_SCAN_END: begin
        ready_d            = 1'b1;
        end_d              = 1'b0;
        bits_d             = '0;
        bcnt_d             = '0;
        done_d             = 1'b1;
        res_d.status       = ST_BUILT;
        res_d.decoded_byte = '0;
        state_d            = BK_IDLE;
      end
      BK_LOOK: begin
        if (dec_hit) begin
          state_d = BK_SYM;
        end else begin
          if (bcnt_q == TW'(MCB)) begin
            bits_d             = '0;
            bcnt_d             = '0;
            done_d             = 1'b1;
            res_d.status       = ST_TOO_LONG;
            res_d.decoded_byte = '0;
          end
          state_d = BK_IDLE;
        end
      end
      BK_SYM: begin
        bits_d = '0;
        bcnt_d = '0;
        done_d = 1'b1;
        if (ord_rd_q == LAST_SYM) begin
          end_d              = 1'b1;
          res_d.status       = ST_END;
          res_d.decoded_byte = '0;
        end else begin
          res_d.status       = ST_BYTE;
          res_d.decoded_byte = 8'(ord_rd_q);
        end
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

endmodule

### rtl/chd_checker.sv
// Port-level checks of the canonical Huffman decoder core and their binding.
`include "canonical_huffman_decoder_core_macros.svh"

module chd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy,
  input logic              done_o,
  input chd_pkg::chd_out_t result_o
);
  import chd_pkg::*;

  // Only a decoded byte carries a non-zero byte field.
  `CHD_ASSERT(a_byte_zero, done_o && (result_o.status != ST_BYTE) |-> result_o.decoded_byte == '0)

  // Results never come back to back.
  `CHD_ASSERT(a_no_back_to_back, done_o |=> !done_o)

  // The length store is being cleared right after reset.
  `CHD_ASSERT(a_busy_after_reset, $rose(rst_ni) |-> busy)

  // No result while the length store is still being cleared and nothing was taken.
  `CHD_ASSERT(a_quiet_while_clearing, $rose(rst_ni) |=> !done_o)

endmodule

bind canonical_huffman_decoder_core chd_checker u_chd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .busy    (busy),
  .done_o  (done_o),
  .result_o(result_o)
);

### tb/chd_checker.sv
// Checker that predicts and compares the result words of the Huffman decoder core.
`timescale 1ns / 1ps

module chd_scoreboard (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  chd_pkg::chd_in_t  item_i,
  input  logic              done_o,
  input  chd_pkg::chd_out_t result_o,
  output int                fail_count,
  output int                words_taken,
  output int                results_seen,
  output int                pending
);
  import chd_pkg::*;

  localparam int NSYM = 257;
  localparam int MAXB = 32;

  // Own copy of the decoder state.
  logic [5:0]  sym_len    [NSYM];
  logic [8:0]  sorted_sym [NSYM];
  int          len_count  [MAXB+1];
  int          len_first  [MAXB+1];
  logic [63:0] len_code   [MAXB+1];
  logic [63:0] gathered;
  int          gathered_n;
  logic        stream_ended;
  logic        tables_built;

  chd_out_t    expected_words[$];

  // Rebuilds the canonical code from the stored lengths.
  task automatic rebuild_code();
    int n, prev, l, i;
    logic [63:0] code;
    n = 0;
    code = '0;
    for (int k = 0; k <= MAXB; k++) begin
      len_count[k] = 0;
      len_first[k] = 0;
      len_code[k]  = '0;
    end
    for (int ln = 0; ln < 64; ln++)
      for (int s = 0; s < NSYM; s++)
        if (sym_len[s] == ln) begin
          sorted_sym[n] = s[8:0];
          n++;
        end
    prev = sym_len[sorted_sym[NSYM-1]];
    for (i = NSYM - 1; i >= 0; i--) begin
      l = sym_len[sorted_sym[i]];
      if (l == 0) break;
      if (l < prev) begin
        code = code >> (prev - l);
        prev = l;
      end
      if (l <= MAXB) begin
        if (len_count[l] == 0) len_code[l] = code;
        len_count[l]++;
        len_first[l] = i;
      end
      code++;
    end
    gathered = '0;
    gathered_n = 0;
    stream_ended = 1'b0;
    tables_built = 1'b1;
  endtask

  // Works out the word, if any, that one accepted input word causes.
  task automatic predict_word(input chd_in_t w);
    chd_out_t r;
    logic [63:0] mask, c;
    int cnt, first;
    logic [8:0] sym;
    case (w.action)
      ACT_LOAD: begin
        if (w.symbol_index < NSYM) sym_len[w.symbol_index] = w.code_length;
      end
      ACT_BUILD: begin
        rebuild_code();
        r.status = ST_BUILT;
        r.decoded_byte = '0;
        expected_words.push_back(r);
      end
      ACT_BIT: begin
        if (tables_built && !stream_ended) begin
          if (gathered_n >= MAXB) gathered_n = 0;
          gathered_n++;
          mask = (64'd1 << gathered_n) - 64'd1;
          gathered = ((gathered << 1) | 64'(w.coded_bit)) & mask;
          cnt = len_count[gathered_n];
          first = len_first[gathered_n];
          for (int i = first; i < first + cnt && i < NSYM; i++) begin
            c = (len_code[gathered_n] + 64'(first + cnt - 1 - i)) & mask;
            if (c == gathered) begin
              sym = sorted_sym[i];
              gathered = '0;
              gathered_n = 0;
              if (sym == NSYM - 1) begin
                stream_ended = 1'b1;
                r.status = ST_END;
                r.decoded_byte = '0;
              end else begin
                r.status = ST_BYTE;
                r.decoded_byte = sym[7:0];
              end
              expected_words.push_back(r);
              return;
            end
          end
          if (gathered_n >= MAXB) begin
            gathered = '0;
            gathered_n = 0;
            r.status = ST_TOO_LONG;
            r.decoded_byte = '0;
            expected_words.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count = 0;
    words_taken = 0;
    results_seen = 0;
    pending = 0;
    for (int s = 0; s < NSYM; s++) begin
      sym_len[s] = '0;
      sorted_sym[s] = '0;
    end
    for (int k = 0; k <= MAXB; k++) begin
      len_count[k] = 0;
      len_first[k] = 0;
      len_code[k] = '0;
    end
    gathered = '0;
    gathered_n = 0;
    stream_ended = 1'b0;
    tables_built = 1'b0;
  end

  // Results are checked before the input of the same edge is predicted,
  // since a word cannot produce its result on the edge that accepts it.
  always @(posedge clk_i) begin
    chd_out_t exp_w;
    if (rst_ni) begin
      if (done_o) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result status %0d byte %0d", $time,
                   result_o.status, result_o.decoded_byte);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (result_o.status !== exp_w.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_w.status, result_o.status);
            fail_count++;
          end
          if (result_o.decoded_byte !== exp_w.decoded_byte) begin
            $display("%0t: decoded_byte expected %0d actual %0d", $time,
                     exp_w.decoded_byte, result_o.decoded_byte);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        words_taken++;
        predict_word(item_i);
      end
      pending = expected_words.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the decoder core.
`timescale 1ns / 1ps

module testbench;
  import chd_pkg::*;

  // Action code that the core does not know.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  chd_in_t  item_i;
  logic     done_o;
  chd_out_t result_o;
  int       fail_count, words_taken, results_seen, pending;

  // Symbols holding a non-zero length from the current code set.
  int       used_syms[$];
  int       sent;
  logic     no_gaps;

  canonical_huffman_decoder_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  chd_scoreboard i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .done_o       (done_o),
    .result_o     (result_o),
    .fail_count   (fail_count),
    .words_taken  (words_taken),
    .results_seen (results_seen),
    .pending      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Guard against a hung core.
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Presents one word after a random gap and holds it until it is taken.
  task automatic send_word(input logic [1:0] act, input int idx, input int len,
                           input logic b);
    chd_in_t w;
    int gap;
    w.action = act;
    w.symbol_index = idx[8:0];
    w.code_length = len[5:0];
    w.coded_bit = b;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    item_i = w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  // Load, build and bit words with random content in the unused fields.
  task automatic load_len(input int idx, input int len);
    send_word(ACT_LOAD, idx, len, 1'($urandom));
  endtask

  task automatic build_code();
    send_word(ACT_BUILD, $urandom_range(0, 511), $urandom_range(0, 63), 1'($urandom));
  endtask

  task automatic coded_bit(input logic b);
    send_word(ACT_BIT, $urandom_range(0, 511), $urandom_range(0, 63), b);
  endtask

  // Zeroes every length of the previous code set.
  task automatic clear_lengths();
    while (used_syms.size() > 0) load_len(used_syms.pop_front(), 0);
  endtask

  // Loads a complete prefix code over random symbols, sometimes spoilt on purpose.
  task automatic load_code_set();
    int lens[$];
    int syms[$];
    int k, pick, l, s;
    bit dup;
    k = $urandom_range(2, 12);
    lens.push_back(0);
    while (lens.size() < k) begin
      pick = $urandom_range(0, lens.size() - 1);
      l = lens[pick];
      lens.delete(pick);
      lens.push_back(l + 1);
      lens.push_back(l + 1);
    end
    if ($urandom_range(0, 1)) syms.push_back(256);
    while (syms.size() < k) begin
      s = $urandom_range(0, 256);
      dup = 0;
      foreach (syms[j]) if (syms[j] == s) dup = 1;
      if (!dup) syms.push_back(s);
    end
    // Over-long or altered lengths break the code now and then.
    if ($urandom_range(0, 3) == 0) lens[$urandom_range(0, k - 1)] = $urandom_range(33, 63);
    if ($urandom_range(0, 4) == 0) lens[$urandom_range(0, k - 1)] = $urandom_range(1, 8);
    for (int j = 0; j < k; j++) begin
      load_len(syms[j], lens[j]);
      used_syms.push_back(syms[j]);
    end
  endtask

  initial begin
    int nbits;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    sent = 0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bit before any build, unknown action, ignored indexes.
    coded_bit(1'b1);
    send_word(ACT_UNKNOWN, 511, 63, 1'b1);
    load_len(0, 1);
    load_len(256, 1);
    load_len(300, 5);
    load_len(511, 63);
    build_code();
    coded_bit(1'b1);
    coded_bit(1'b0);
    coded_bit(1'b1);
    // A code only reachable with all 32 bits, and one longer than the limit.
    load_len(0, 0);
    load_len(256, 0);
    load_len(255, 32);
    load_len(7, 33);
    build_code();
    for (int i = 0; i < 32; i++) coded_bit(1'b1);
    for (int i = 0; i < 32; i++) coded_bit(1'b0);
    // Duplicate codes at one length.
    load_len(255, 0);
    load_len(7, 0);
    used_syms = '{1, 2, 3};
    foreach (used_syms[j]) load_len(used_syms[j], 1);
    build_code();
    coded_bit(1'b0);
    coded_bit(1'b1);

    // Random phases: a fresh code set, a build, then a stream of bits.
    while (sent < 1850) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      clear_lengths();
      load_code_set();
      if ($urandom_range(0, 2) == 0) begin
        send_word(ACT_UNKNOWN, $urandom_range(0, 511), $urandom_range(0, 63), 1'($urandom));
        load_len($urandom_range(257, 511), $urandom_range(0, 63));
      end
      build_code();
      nbits = $urandom_range(40, 120);
      for (int i = 0; i < nbits; i++) begin
        if ($urandom_range(0, 19) == 0) load_len($urandom_range(257, 511), $urandom_range(0, 63));
        else coded_bit(1'($urandom));
      end
    end
    start = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words over random code sets; %0d result words checked.",
             words_taken, results_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/chd_pkg.sv
rtl/chd_queue.sv
rtl/chd_front.sv
rtl/chd_back.sv
rtl/canonical_huffman_decoder_core.sv
rtl/chd_checker.sv
tb/chd_checker.sv
tb/testbench.sv
